[rtl/core/bma_pkg.sv]
// ----------------------------------------------------------------------------
// bma_pkg
// Shared codes and controller/datapath interface types for the buddy
// allocator core.
// ----------------------------------------------------------------------------
package bma_pkg;

   localparam int CMD_W   = 2;
   localparam int OWNER_W = 8;
   localparam int REQ_W   = 21;
   localparam int OFF_W   = 20;
   localparam int SIZE_W  = 21;
   localparam int STAT_W  = 2;
   localparam int CFG_W   = 5;

   localparam int RESET_ORDER = 10;

   localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DUMP    = 2'd2;

   localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
   localparam logic [STAT_W-1:0] ST_NO_FIT     = 2'd1;
   localparam logic [STAT_W-1:0] ST_NO_OWNER   = 2'd2;
   localparam logic [STAT_W-1:0] ST_TABLE_FULL = 2'd3;

   // sequencer steps, also the controller state codes
   localparam int OP_W = 4;
   localparam logic [OP_W-1:0] OP_INIT   = 4'd0;
   localparam logic [OP_W-1:0] OP_IDLE   = 4'd1;
   localparam logic [OP_W-1:0] OP_ASCAN  = 4'd2;
   localparam logic [OP_W-1:0] OP_AEVAL  = 4'd3;
   localparam logic [OP_W-1:0] OP_KCALC  = 4'd4;
   localparam logic [OP_W-1:0] OP_ACHK   = 4'd5;
   localparam logic [OP_W-1:0] OP_SHIFT  = 4'd6;
   localparam logic [OP_W-1:0] OP_FILL   = 4'd7;
   localparam logic [OP_W-1:0] OP_AFIN   = 4'd8;
   localparam logic [OP_W-1:0] OP_RSCAN  = 4'd9;
   localparam logic [OP_W-1:0] OP_MSTART = 4'd10;
   localparam logic [OP_W-1:0] OP_MFIRST = 4'd11;
   localparam logic [OP_W-1:0] OP_MSCAN  = 4'd12;
   localparam logic [OP_W-1:0] OP_MDEL   = 4'd13;
   localparam logic [OP_W-1:0] OP_DUMP   = 4'd14;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            accept;
   } bma_cmd_type;

   typedef struct packed {
      logic last;
      logic found;
      logic k_step;
      logic full;
      logic no_split;
      logic at_best;
      logic fill_last;
      logic match;
      logic cnt_one;
      logic pair;
      logic del_done;
      logic rsp_busy;
      logic rsp_free;
   } bma_stat_type;

endpackage

[rtl/core/buddy_memory_allocator_core.sv]
// ----------------------------------------------------------------------------
// buddy_memory_allocator_core
// Buddy allocator over 2^total_order units, block list kept in a RAM table.
//
//   channel  direction  handshake            word
//   req_     in         req_valid/req_stall  command, owner, request_size
//   rsp_     out        rsp_valid/rsp_stall  status, block fields, last
//   csr_     in         csr_wr_en            total_order
//
// Allocate: a best-fit scan, then a split of the chosen block when it is
// larger than needed, moving the later entries up. Release: a scan for the
// owner, then merge passes. Dump: N words, one per cycle when rsp_stall is
// low. N = block count.
// Sync reset; the init state writes the first table entry.
// One request in flight; req_stall holds while busy or a word waits.
// ----------------------------------------------------------------------------
module buddy_memory_allocator_core
   import bma_pkg::*;
#(
   parameter int MAX_BLOCKS = 32,
   parameter int MAX_ORDER  = 20
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [CMD_W-1:0]    req_command,
   input  logic [OWNER_W-1:0]  req_owner,
   input  logic [REQ_W-1:0]    req_request_size,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STAT_W-1:0]   rsp_status,
   output logic [OFF_W-1:0]    rsp_block_offset,
   output logic [SIZE_W-1:0]   rsp_block_size,
   output logic                rsp_is_free,
   output logic [OWNER_W-1:0]  rsp_block_owner,
   output logic [REQ_W-1:0]    rsp_used_size,
   output logic                rsp_last,
   input  logic                csr_wr_en,
   input  logic [CFG_W-1:0]    csr_wr_data
);

   bma_cmd_type  cmd;
   bma_stat_type st;

   bma_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_command (req_command),
      .st          (st),
      .cmd         (cmd)
   );

   bma_dpath #(
      .MAX_BLOCKS(MAX_BLOCKS),
      .MAX_ORDER (MAX_ORDER)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .st               (st),
      .req_owner        (req_owner),
      .req_request_size (req_request_size),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_block_offset (rsp_block_offset),
      .rsp_block_size   (rsp_block_size),
      .rsp_is_free      (rsp_is_free),
      .rsp_block_owner  (rsp_block_owner),
      .rsp_used_size    (rsp_used_size),
      .rsp_last         (rsp_last)
   );

   a_no_accept_with_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while a result word waits");

   // an unknown command is dropped in place, so only real commands hold the input
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall &&
       (req_command == CMD_ALLOC || req_command == CMD_RELEASE ||
        req_command == CMD_DUMP)) |=> req_stall)
      else $error("second request taken back to back");

   a_refusal_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |->
         (rsp_block_size == '0 && rsp_last && !rsp_is_free))
      else $error("refused request carries block data");

   a_free_no_owner: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_free) |-> (rsp_block_owner == '0 && rsp_used_size == '0))
      else $error("free block reports an owner");

endmodule

[rtl/core/bma_ram.sv]
// ----------------------------------------------------------------------------
// bma_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module bma_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

[rtl/core/bma_ctrl.sv]
// ----------------------------------------------------------------------------
// bma_ctrl
// Sequencer for the allocator: walks each request through scan, split,
// merge and list steps, driven by datapath status.
// ----------------------------------------------------------------------------
module bma_ctrl
   import bma_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [CMD_W-1:0]   req_command,
   input  bma_stat_type       st,
   output bma_cmd_type        cmd
);

   logic [OP_W-1:0] state_ff, state_in;
   logic            accept;

   assign req_stall  = (state_ff != OP_IDLE) || st.rsp_busy;
   assign accept     = req_valid && !req_stall;
   assign cmd.op     = state_ff;
   assign cmd.accept = accept;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         OP_INIT: state_in = OP_IDLE;
         OP_IDLE: begin
            if (accept) begin
               case (req_command)
                  CMD_ALLOC:   state_in = OP_ASCAN;
                  CMD_RELEASE: state_in = OP_RSCAN;
                  CMD_DUMP:    state_in = OP_DUMP;
                  default:     state_in = OP_IDLE;
               endcase
            end
         end
         OP_ASCAN:  if (st.last) state_in = OP_AEVAL;
         OP_AEVAL:  state_in = st.found ? OP_KCALC : OP_IDLE;
         OP_KCALC:  if (!st.k_step) state_in = OP_ACHK;
         OP_ACHK: begin
            if (st.full)          state_in = OP_IDLE;
            else if (st.no_split) state_in = OP_AFIN;
            else                  state_in = OP_SHIFT;
         end
         OP_SHIFT:  if (st.at_best) state_in = OP_FILL;
         OP_FILL:   if (st.fill_last) state_in = OP_AFIN;
         OP_AFIN:   state_in = OP_IDLE;
         OP_RSCAN: begin
            if (st.match)     state_in = OP_MSTART;
            else if (st.last) state_in = OP_IDLE;
         end
         OP_MSTART: state_in = OP_MFIRST;
         OP_MFIRST: state_in = st.cnt_one ? OP_IDLE : OP_MSCAN;
         OP_MSCAN: begin
            if (st.pair)      state_in = OP_MDEL;
            else if (st.last) state_in = OP_IDLE;
         end
         OP_MDEL:   if (st.del_done) state_in = OP_MSTART;
         OP_DUMP:   if (st.rsp_free && st.last) state_in = OP_IDLE;
         default:   state_in = OP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= OP_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/core/bma_dpath.sv]
// ----------------------------------------------------------------------------
// bma_dpath
// Block table RAM, walk counters, best-fit tracking and the result register.
// ----------------------------------------------------------------------------
module bma_dpath
   import bma_pkg::*;
#(
   parameter int MAX_BLOCKS = 32,
   parameter int MAX_ORDER  = 20
) (
   input  logic                clock,
   input  logic                reset,
   input  bma_cmd_type         cmd,
   output bma_stat_type        st,
   input  logic [OWNER_W-1:0]  req_owner,
   input  logic [REQ_W-1:0]    req_request_size,
   input  logic                csr_wr_en,
   input  logic [CFG_W-1:0]    csr_wr_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STAT_W-1:0]   rsp_status,
   output logic [OFF_W-1:0]    rsp_block_offset,
   output logic [SIZE_W-1:0]   rsp_block_size,
   output logic                rsp_is_free,
   output logic [OWNER_W-1:0]  rsp_block_owner,
   output logic [REQ_W-1:0]    rsp_used_size,
   output logic                rsp_last
);

   localparam int AW = $clog2(MAX_BLOCKS);
   localparam int IW = $clog2(MAX_BLOCKS + 1);
   localparam int OW = $clog2(MAX_ORDER + 1);
   localparam int SW = (MAX_ORDER + 1 > SIZE_W) ? MAX_ORDER + 1 : SIZE_W;
   localparam int EW = OW + 1 + OWNER_W + REQ_W;
   localparam logic [OW-1:0] INIT_ORD =
      OW'((RESET_ORDER > MAX_ORDER) ? MAX_ORDER : RESET_ORDER);

   function automatic logic [SW-1:0] blk_size(input logic [OW-1:0] o);
      return SW'(1) << o;
   endfunction

   // table entry: {order, busy, owner, used}
   function automatic logic [EW-1:0] mk_entry(input logic [OW-1:0] o,
                                              input logic busy,
                                              input logic [OWNER_W-1:0] own,
                                              input logic [REQ_W-1:0] used);
      return {o, busy, own, used};
   endfunction

   // registers
   logic [OW-1:0]      total_ff, total_in;
   logic [IW-1:0]      cnt_ff, cnt_in;
   logic [IW-1:0]      idx_ff, idx_in;
   logic [SW-1:0]      off_ff, off_in;
   logic               best_found_ff, best_found_in;
   logic [IW-1:0]      best_idx_ff, best_idx_in;
   logic [OW-1:0]      best_ord_ff, best_ord_in;
   logic [SW-1:0]      best_off_ff, best_off_in;
   logic [OW-1:0]      k_ff, k_in;
   logic [OW-1:0]      splits_ff, splits_in;
   logic [OW-1:0]      fill_ord_ff, fill_ord_in;
   logic [OWNER_W-1:0] owner_ff, owner_in;
   logic [REQ_W-1:0]   req_ff, req_in;
   logic [OW-1:0]      prev_ord_ff, prev_ord_in;
   logic               prev_busy_ff, prev_busy_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]  rsp_status_ff;
   logic [OFF_W-1:0]   rsp_off_ff;
   logic [SIZE_W-1:0]  rsp_size_ff;
   logic               rsp_free_ff;
   logic [OWNER_W-1:0] rsp_own_ff;
   logic [REQ_W-1:0]   rsp_used_ff;
   logic               rsp_last_ff;

   // result load
   logic               ld;
   logic [STAT_W-1:0]  ld_status;
   logic [SW-1:0]      ld_off;
   logic [SW-1:0]      ld_size;
   logic               ld_free;
   logic [OWNER_W-1:0] ld_own;
   logic [REQ_W-1:0]   ld_used;
   logic               ld_last;

   // memory port
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [EW-1:0]      wr_data;
   logic [EW-1:0]      rd_data;

   // current entry and derived terms
   logic [OW-1:0]      e_ord;
   logic               e_busy;
   logic [OWNER_W-1:0] e_own;
   logic [REQ_W-1:0]   e_used;
   logic [SW-1:0]      e_size;
   logic [SW-1:0]      req_ext;
   logic [OW-1:0]      splits;
   logic [IW-1:0]      shift_dst;
   logic [IW-1:0]      fill_end;
   logic [IW-1:0]      idx_prev;
   logic               fits;
   logic               rsp_free;
   logic [OW-1:0]      csr_ord;

   assign e_ord   = rd_data[EW-1 -: OW];
   assign e_busy  = rd_data[OWNER_W + REQ_W];
   assign e_own   = rd_data[REQ_W +: OWNER_W];
   assign e_used  = rd_data[REQ_W-1:0];
   assign e_size  = blk_size(e_ord);
   assign req_ext = SW'(req_ff);
   assign splits  = best_ord_ff - k_ff;
   assign shift_dst = idx_ff + IW'(splits_ff);
   assign fill_end  = best_idx_ff + IW'(splits_ff);
   assign idx_prev  = idx_ff - IW'(1);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ord   = (csr_wr_data > CFG_W'(MAX_ORDER)) ? OW'(MAX_ORDER)
                                                         : OW'(csr_wr_data);

   assign fits = !e_busy && (e_size >= req_ext) &&
                 (!best_found_ff || (e_ord < best_ord_ff));

   always_comb begin
      st.last      = (idx_ff == cnt_ff - IW'(1));
      st.found     = best_found_ff;
      st.k_step    = (k_ff != '0) && (blk_size(k_ff - OW'(1)) >= req_ext);
      st.full      = (int'(cnt_ff) + int'(splits)) > MAX_BLOCKS;
      st.no_split  = (splits == '0);
      st.at_best   = (idx_ff == best_idx_ff);
      st.fill_last = (idx_ff == fill_end);
      st.match     = e_busy && (e_own == owner_ff);
      st.cnt_one   = (cnt_ff == IW'(1));
      st.pair      = !prev_busy_ff && !e_busy && (e_ord == prev_ord_ff) &&
                     !off_ff[prev_ord_ff];
      st.del_done  = (idx_ff == cnt_ff);
      st.rsp_busy  = rsp_valid_ff;
      st.rsp_free  = rsp_free;
   end

   always_comb begin
      total_in      = total_ff;
      cnt_in        = cnt_ff;
      idx_in        = idx_ff;
      off_in        = off_ff;
      best_found_in = best_found_ff;
      best_idx_in   = best_idx_ff;
      best_ord_in   = best_ord_ff;
      best_off_in   = best_off_ff;
      k_in          = k_ff;
      splits_in     = splits_ff;
      fill_ord_in   = fill_ord_ff;
      owner_in      = owner_ff;
      req_in        = req_ff;
      prev_ord_in   = prev_ord_ff;
      prev_busy_in  = prev_busy_ff;
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_data   = '0;
      ld        = 1'b0;
      ld_status = ST_OK;
      ld_off    = '0;
      ld_size   = '0;
      ld_free   = 1'b0;
      ld_own    = '0;
      ld_used   = '0;
      ld_last   = 1'b1;

      case (cmd.op)
         OP_INIT: begin
            wr_en   = 1'b1;
            wr_data = mk_entry(total_ff, 1'b0, '0, '0);
            cnt_in  = IW'(1);
         end
         OP_IDLE: begin
            idx_in        = '0;
            off_in        = '0;
            best_found_in = 1'b0;
            if (cmd.accept) begin
               owner_in = req_owner;
               // zero units counts as one
               req_in   = (req_request_size == '0) ? REQ_W'(1) : req_request_size;
            end
         end
         OP_ASCAN: begin
            if (fits) begin
               best_found_in = 1'b1;
               best_idx_in   = idx_ff;
               best_ord_in   = e_ord;
               best_off_in   = off_ff;
            end
            off_in = off_ff + e_size;
            if (!st.last) idx_in = idx_ff + IW'(1);
         end
         OP_AEVAL: begin
            if (!best_found_ff) begin
               ld        = 1'b1;
               ld_status = ST_NO_FIT;
            end
            k_in = best_ord_ff;
         end
         OP_KCALC: begin
            if (st.k_step) k_in = k_ff - OW'(1);
         end
         OP_ACHK: begin
            splits_in = splits;
            if (st.full) begin
               ld        = 1'b1;
               ld_status = ST_TABLE_FULL;
            end
            idx_in = cnt_ff - IW'(1);
         end
         OP_SHIFT: begin
            // move the tail up, top entry first
            if (st.at_best) begin
               idx_in      = best_idx_ff + IW'(1);
               fill_ord_in = k_ff;
            end else begin
               wr_en   = 1'b1;
               wr_addr = shift_dst[AW-1:0];
               wr_data = rd_data;
               idx_in  = idx_ff - IW'(1);
            end
         end
         OP_FILL: begin
            wr_en       = 1'b1;
            wr_addr     = idx_ff[AW-1:0];
            wr_data     = mk_entry(fill_ord_ff, 1'b0, '0, '0);
            fill_ord_in = fill_ord_ff + OW'(1);
            idx_in      = idx_ff + IW'(1);
         end
         OP_AFIN: begin
            wr_en   = 1'b1;
            wr_addr = best_idx_ff[AW-1:0];
            wr_data = mk_entry(k_ff, 1'b1, owner_ff, req_ff);
            cnt_in  = cnt_ff + IW'(splits_ff);
            ld      = 1'b1;
            ld_off  = best_off_ff;
            ld_size = blk_size(k_ff);
            ld_own  = owner_ff;
            ld_used = req_ff;
         end
         OP_RSCAN: begin
            if (st.match) begin
               wr_en   = 1'b1;
               wr_addr = idx_ff[AW-1:0];
               wr_data = mk_entry(e_ord, 1'b0, '0, '0);
               ld      = 1'b1;
               ld_off  = off_ff;
               ld_size = e_size;
               ld_free = 1'b1;
            end else begin
               off_in = off_ff + e_size;
               if (st.last) begin
                  ld        = 1'b1;
                  ld_status = ST_NO_OWNER;
               end else begin
                  idx_in = idx_ff + IW'(1);
               end
            end
         end
         OP_MSTART: begin
            idx_in = '0;
            off_in = '0;
         end
         OP_MFIRST: begin
            prev_ord_in  = e_ord;
            prev_busy_in = e_busy;
            idx_in       = IW'(1);
         end
         OP_MSCAN: begin
            // off holds the offset of the lower member
            if (st.pair) begin
               wr_en   = 1'b1;
               wr_addr = idx_prev[AW-1:0];
               wr_data = mk_entry(prev_ord_ff + OW'(1), 1'b0, '0, '0);
               idx_in  = idx_ff + IW'(1);
            end else if (!st.last) begin
               prev_ord_in  = e_ord;
               prev_busy_in = e_busy;
               off_in       = off_ff + blk_size(prev_ord_ff);
               idx_in       = idx_ff + IW'(1);
            end
         end
         OP_MDEL: begin
            if (st.del_done) begin
               cnt_in = cnt_ff - IW'(1);
            end else begin
               wr_en   = 1'b1;
               wr_addr = idx_prev[AW-1:0];
               wr_data = rd_data;
               idx_in  = idx_ff + IW'(1);
            end
         end
         OP_DUMP: begin
            if (rsp_free) begin
               ld      = 1'b1;
               ld_off  = off_ff;
               ld_size = e_size;
               ld_free = !e_busy;
               ld_own  = e_busy ? e_own : '0;
               ld_used = e_busy ? e_used : '0;
               ld_last = st.last;
               off_in  = off_ff + e_size;
               idx_in  = idx_ff + IW'(1);
            end
         end
         default: begin
         end
      endcase

      // region write restarts the table with one free block
      if (csr_wr_en) begin
         total_in = csr_ord;
         cnt_in   = IW'(1);
         wr_en    = 1'b1;
         wr_addr  = '0;
         wr_data  = mk_entry(csr_ord, 1'b0, '0, '0);
      end
   end

   assign rsp_valid_in = ld ? 1'b1 : (rsp_valid_ff && rsp_stall);

   // read address follows the next index, so rd_data is entry[idx_ff]
   bma_ram #(
      .WIDTH(EW),
      .DEPTH(MAX_BLOCKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_in[AW-1:0]),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= INIT_ORD;
         cnt_ff       <= IW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         total_ff     <= total_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      off_ff        <= off_in;
      best_found_ff <= best_found_in;
      best_idx_ff   <= best_idx_in;
      best_ord_ff   <= best_ord_in;
      best_off_ff   <= best_off_in;
      k_ff          <= k_in;
      splits_ff     <= splits_in;
      fill_ord_ff   <= fill_ord_in;
      owner_ff      <= owner_in;
      req_ff        <= req_in;
      prev_ord_ff   <= prev_ord_in;
      prev_busy_ff  <= prev_busy_in;
      if (ld) begin
         rsp_status_ff <= ld_status;
         rsp_off_ff    <= ld_off[OFF_W-1:0];
         rsp_size_ff   <= ld_size[SIZE_W-1:0];
         rsp_free_ff   <= ld_free;
         rsp_own_ff    <= ld_own;
         rsp_used_ff   <= ld_used;
         rsp_last_ff   <= ld_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_block_offset = rsp_off_ff;
   assign rsp_block_size   = rsp_size_ff;
   assign rsp_is_free      = rsp_free_ff;
   assign rsp_block_owner  = rsp_own_ff;
   assign rsp_used_size    = rsp_used_ff;
   assign rsp_last         = rsp_last_ff;

endmodule
